FILE: hdl/adsr_tone_voice_top_macros.svh
// Assertion macros for the voice port checker
`ifndef ADSR_TONE_VOICE_TOP_MACROS_SVH
`define ADSR_TONE_VOICE_TOP_MACROS_SVH
// same-cycle implication, disabled in reset
`define ATV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define ATV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/atv_pkg.sv
// Shared constants, types and sine table builder for the tone voice
package atv_pkg;

    localparam int SINE_TABLE_SIZE = 1024;
    localparam int COUNT_BITS      = 20;
    localparam int TIME_W          = 20;
    localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
    localparam int QTAB_LEN        = SINE_TABLE_SIZE / 4 + 1;
    localparam int Z_STEP          = 65536 / SINE_TABLE_SIZE;

    localparam int EW      = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;
    localparam int MUL_A_W = EW;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_Q_W = 16;
    localparam int DIV_N_W = EW + DIV_Q_W;
    localparam int DIV_D_W = TIME_W;

    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_TIMES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VIBRATO      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO      = 3'd7;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    localparam logic [30:0] RST_PHASE_STEP = 31'd42852282;
    localparam logic [15:0] RST_AMPLITUDE  = 16'd26214;
    localparam logic [15:0] RST_SUSTAIN    = 16'd32768;
    localparam logic [19:0] RST_DURATION   = 20'd44100;
    localparam logic [15:0] RST_LFSR       = 16'hACE1;
    localparam logic [15:0] LFSR_MASK      = 16'hB400;
    localparam logic [15:0] DEFAULT_AMP    = 16'd26214;
    localparam logic [15:0] Q_ONE          = 16'd32768;

    typedef logic [14:0] qtab_t [QTAB_LEN];

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
    } div_req_t;

    // quarter-wave quintic, evaluated at elaboration
    function automatic qtab_t build_qtab();
        qtab_t  tab;
        longint z;
        longint z2;
        longint t;
        int     k;
        for (k = 0; k < QTAB_LEN; k++)
        begin
            z  = longint'(k) * Z_STEP;
            z2 = (z * z) >>> 14;
            t  = (5223 * z2) >>> 14;
            t  = 42334 - t;
            t  = (t * z2) >>> 14;
            t  = 102944 - t;
            t  = (t * z) >>> 15;
            if (t > 32767)
            begin
                t = 32767;
            end
            tab[k] = t[14:0];
        end
        return tab;
    endfunction

endpackage

FILE: hdl/adsr_tone_voice_top.sv
// Synth voice top: sequencer, envelope and oscillator state, config and ports
//
// One tick beat in (restart bit), one sample beat out (sample, last, playing).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Config is a plain write port (cfg_we, cfg_index, cfg_data), idle-time only;
// the user must keep to this, the block itself does not enforce it.
// Works on one tick at a time: in_stall is low only while the sequencer idles.
// All products run through one bit-serial multiplier (up to seven per tick)
// and the envelope ramps through one bit-serial divider. The time from
// acceptance of a playing tick to its sample beat is set by which modulators
// and envelope phase are active; an idle tick skips the datapath.
// The result is held in an output register, so the next tick is accepted
// and computed while a stalled sample waits; the sequencer then holds
// before its last step until the output register frees.
// Reset restores the default register set, stops the note, zeroes all
// phases and reseeds the noise LFSR; no sample beat is pending after reset.
module adsr_tone_voice_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [atv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atv_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            sample,
    output logic                          last,
    output logic                          playing
);
    import atv_pkg::*;

    localparam int XW = EW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_VIB_RD, S_VIB_GO, S_VIB_WT, S_PHASE, S_TRM_RD, S_TRM_GO,
        S_TRM_WT, S_WAV_RD, S_WAV_GO, S_AMP_WT, S_ENV, S_ENV_MW, S_ENV_DW,
        S_EMUL, S_EMUL_WT, S_TMUL, S_TMUL_WT, S_FMUL, S_FMUL_WT, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ENV_ATT, ENV_DEC, ENV_SUS, ENV_REL, ENV_ZERO
    } env_case_t;

    state_t state_reg;

    logic [2:0]         shape_reg;
    logic [30:0]        pstep_reg;
    logic [15:0]        amp_reg;
    logic [59:0]        etimes_reg;
    logic [15:0]        sus_reg;
    logic [19:0]        dur_reg;
    logic [31:0]        vib_reg;
    logic [31:0]        trm_reg;

    logic [COUNT_BITS-1:0] idx_reg;
    logic [31:0]        osc_reg;
    logic [23:0]        vph_reg;
    logic [23:0]        tph_reg;
    logic [15:0]        lfsr_reg;
    logic               active_reg;

    logic signed [32:0] step_reg;
    logic signed [17:0] trem_reg;
    logic               neg_reg;
    logic [17:0]        vmag_reg;
    logic [15:0]        env_reg;
    logic [TIME_W-1:0]  ediv_reg;
    logic               esub_reg;
    logic signed [15:0] res_sample_reg;
    logic               res_last_reg;
    logic               res_play_reg;

    logic               ov_reg;
    logic signed [15:0] sample_reg;
    logic               last_reg;
    logic               play_reg;

    logic [31:0]        sine_phase;
    logic signed [15:0] sine_q;
    logic [15:0]        sine_abs;
    logic [15:0]        vrate;
    logic [15:0]        trate;
    logic [TIME_W-1:0]  a_t;
    logic [TIME_W-1:0]  d_t;
    logic [TIME_W-1:0]  r_t;
    logic [15:0]        s_eff;
    logic [15:0]        amp_eff;
    logic [XW-1:0]      i_x;
    logic               c_att;
    logic               c_dec;
    logic               c_sus;
    logic [EW-1:0]      num;
    logic [EW-1:0]      i_minus_a;
    env_case_t          env_case;
    logic signed [17:0] wave_w;
    logic [17:0]        p15;
    logic [15:0]        wave_mag;
    logic [15:0]        lfsr_next;
    logic [16:0]        vq;
    logic signed [32:0] vdelta;
    logic [15:0]        trem_abs;
    logic [17:0]        tprod;
    logic [15:0]        fres;
    logic               start_active;

    mul_req_t           mul_req;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_q;

    atv_sine u_sine (
        .clk   (clk),
        .phase (sine_phase),
        .value (sine_q)
    );

    atv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_p)
    );

    atv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    assign vrate    = vib_reg[15:0];
    assign trate    = trm_reg[15:0];
    assign a_t      = etimes_reg[19:0];
    assign d_t      = etimes_reg[39:20];
    assign r_t      = etimes_reg[59:40];
    assign s_eff    = (sus_reg == 16'd0 || sus_reg > Q_ONE) ? Q_ONE : sus_reg;
    assign amp_eff  = (amp_reg == 16'd0) ? DEFAULT_AMP : amp_reg;
    assign sine_abs = 16'(sine_q[15] ? -sine_q : sine_q);
    assign trem_abs = 16'(trem_reg[17] ? -trem_reg : trem_reg);

    assign i_x       = XW'(idx_reg);
    assign c_att     = (a_t != '0) && (i_x < XW'(a_t));
    assign c_dec     = (d_t != '0) && (i_x < (XW'(a_t) + XW'(d_t)));
    assign c_sus     = (i_x + XW'(r_t)) < XW'(dur_reg);
    assign num       = (XW'(dur_reg) > i_x) ? EW'(XW'(dur_reg) - i_x) : '0;
    assign i_minus_a = EW'(i_x - XW'(a_t));

    always_comb
    begin
        if (c_att)
        begin
            env_case = ENV_ATT;
        end
        else if (c_dec)
        begin
            env_case = ENV_DEC;
        end
        else if (c_sus)
        begin
            env_case = ENV_SUS;
        end
        else if (r_t != '0)
        begin
            env_case = ENV_REL;
        end
        else
        begin
            env_case = ENV_ZERO;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_VIB_RD: sine_phase = {vph_reg, 8'd0};
            S_TRM_RD: sine_phase = {tph_reg, 8'd0};
            default:  sine_phase = osc_reg;
        endcase
    end

    assign lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_MASK : 16'd0);
    assign p15       = {1'b0, osc_reg[31:15]};

    always_comb
    begin
        case (shape_reg)
            WAVE_SINE:     wave_w = 18'(sine_q);
            WAVE_SQUARE:   wave_w = osc_reg[31] ? -18'sd32768 : 18'sd32768;
            WAVE_SAW:      wave_w = $signed({2'b0, osc_reg[31:16]}) - 18'sd32768;
            WAVE_TRIANGLE: wave_w = osc_reg[31] ? (18'sd98304 - $signed(p15))
                                                : ($signed(p15) - 18'sd32768);
            WAVE_NOISE:    wave_w = $signed({2'b0, lfsr_reg}) - 18'sd32768;
            default:       wave_w = '0;
        endcase
    end

    assign wave_mag = 16'(wave_w[17] ? -wave_w : wave_w);
    assign vq       = mul_p[31:15];
    assign vdelta   = neg_reg ? -$signed({16'd0, vq}) : $signed({16'd0, vq});
    assign tprod    = mul_p[32:15];
    assign fres     = mul_p[30:15];
    assign start_active = restart ? (dur_reg != 20'd0) : active_reg;

    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            S_VIB_GO:
            begin
                mul_req.start = (vrate != 16'd0);
                mul_req.a     = MUL_A_W'(sine_abs);
                mul_req.b     = vib_reg[31:16];
            end
            S_TRM_GO:
            begin
                mul_req.start = (trate != 16'd0);
                mul_req.a     = MUL_A_W'({~sine_q[15], sine_q[14:0]});
                mul_req.b     = trm_reg[31:16];
            end
            S_WAV_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(wave_mag);
                mul_req.b     = amp_eff;
            end
            S_ENV:
            begin
                mul_req.start = (env_case == ENV_DEC) || (env_case == ENV_REL);
                mul_req.a     = (env_case == ENV_DEC) ? i_minus_a : num;
                mul_req.b     = (env_case == ENV_DEC) ? 16'(17'd32768 - {1'b0, s_eff})
                                                      : s_eff;
            end
            S_EMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(vmag_reg);
                mul_req.b     = env_reg;
            end
            S_TMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(vmag_reg);
                mul_req.b     = trem_abs;
            end
            S_FMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(vmag_reg);
                mul_req.b     = 16'd32767;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_ENV:
            begin
                div_req.start = (env_case == ENV_ATT);
                div_req.n     = DIV_N_W'({idx_reg, 15'd0});
                div_req.d     = a_t;
            end
            S_ENV_MW:
            begin
                div_req.start = mul_done;
                div_req.n     = DIV_N_W'(mul_p);
                div_req.d     = ediv_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            shape_reg      <= WAVE_SINE;
            pstep_reg      <= RST_PHASE_STEP;
            amp_reg        <= RST_AMPLITUDE;
            etimes_reg     <= '0;
            sus_reg        <= RST_SUSTAIN;
            dur_reg        <= RST_DURATION;
            vib_reg        <= '0;
            trm_reg        <= '0;
            idx_reg        <= '0;
            osc_reg        <= '0;
            vph_reg        <= '0;
            tph_reg        <= '0;
            lfsr_reg       <= RST_LFSR;
            active_reg     <= 1'b0;
            step_reg       <= '0;
            trem_reg       <= '0;
            neg_reg        <= 1'b0;
            vmag_reg       <= '0;
            env_reg        <= '0;
            ediv_reg       <= '0;
            esub_reg       <= 1'b0;
            res_sample_reg <= '0;
            res_last_reg   <= 1'b0;
            res_play_reg   <= 1'b0;
            ov_reg         <= 1'b0;
            sample_reg     <= '0;
            last_reg       <= 1'b0;
            play_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WAVE_SHAPE: shape_reg  <= cfg_data[2:0];
                    CFG_PHASE_STEP: pstep_reg  <= cfg_data[30:0];
                    CFG_AMPLITUDE:  amp_reg    <= cfg_data[15:0];
                    CFG_ENV_TIMES:  etimes_reg <= cfg_data[59:0];
                    CFG_SUSTAIN:    sus_reg    <= cfg_data[15:0];
                    CFG_DURATION:   dur_reg    <= cfg_data[19:0];
                    CFG_VIBRATO:    vib_reg    <= cfg_data[31:0];
                    CFG_TREMOLO:    trm_reg    <= cfg_data[31:0];
                    default:        shape_reg  <= shape_reg;
                endcase
            end

            // S_DONE reloads the output register itself
            if (ov_reg && !out_stall && state_reg != S_DONE)
            begin
                ov_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (restart)
                        begin
                            idx_reg    <= '0;
                            osc_reg    <= '0;
                            vph_reg    <= '0;
                            tph_reg    <= '0;
                            active_reg <= (dur_reg != 20'd0);
                        end
                        if (start_active)
                        begin
                            state_reg <= S_VIB_RD;
                        end
                        else
                        begin
                            res_sample_reg <= '0;
                            res_last_reg   <= 1'b0;
                            res_play_reg   <= 1'b0;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_VIB_RD:
                begin
                    state_reg <= S_VIB_GO;
                end
                S_VIB_GO:
                begin
                    vph_reg <= vph_reg + 24'(vrate);
                    neg_reg <= sine_q[15];
                    if (vrate != 16'd0)
                    begin
                        state_reg <= S_VIB_WT;
                    end
                    else
                    begin
                        step_reg  <= $signed({2'b0, pstep_reg});
                        state_reg <= S_PHASE;
                    end
                end
                S_VIB_WT:
                begin
                    if (mul_done)
                    begin
                        step_reg  <= $signed({2'b0, pstep_reg}) + vdelta;
                        state_reg <= S_PHASE;
                    end
                end
                S_PHASE:
                begin
                    osc_reg   <= osc_reg + step_reg[31:0];
                    state_reg <= S_TRM_RD;
                end
                S_TRM_RD:
                begin
                    state_reg <= S_TRM_GO;
                end
                S_TRM_GO:
                begin
                    tph_reg <= tph_reg + 24'(trate);
                    if (trate != 16'd0)
                    begin
                        state_reg <= S_TRM_WT;
                    end
                    else
                    begin
                        trem_reg  <= 18'sd32768;
                        state_reg <= S_WAV_RD;
                    end
                end
                S_TRM_WT:
                begin
                    if (mul_done)
                    begin
                        trem_reg  <= 18'sd32768 - $signed({2'b0, mul_p[31:16]});
                        state_reg <= S_WAV_RD;
                    end
                end
                S_WAV_RD:
                begin
                    if (shape_reg == WAVE_NOISE)
                    begin
                        lfsr_reg <= lfsr_next;
                    end
                    state_reg <= S_WAV_GO;
                end
                S_WAV_GO:
                begin
                    neg_reg   <= wave_w[17];
                    state_reg <= S_AMP_WT;
                end
                S_AMP_WT:
                begin
                    if (mul_done)
                    begin
                        vmag_reg  <= tprod;
                        state_reg <= S_ENV;
                    end
                end
                S_ENV:
                begin
                    case (env_case)
                        ENV_ATT:
                        begin
                            esub_reg  <= 1'b0;
                            state_reg <= S_ENV_DW;
                        end
                        ENV_DEC:
                        begin
                            ediv_reg  <= d_t;
                            esub_reg  <= 1'b1;
                            state_reg <= S_ENV_MW;
                        end
                        ENV_REL:
                        begin
                            ediv_reg  <= r_t;
                            esub_reg  <= 1'b0;
                            state_reg <= S_ENV_MW;
                        end
                        ENV_SUS:
                        begin
                            env_reg   <= s_eff;
                            state_reg <= S_EMUL;
                        end
                        default:
                        begin
                            env_reg   <= '0;
                            state_reg <= S_EMUL;
                        end
                    endcase
                end
                S_ENV_MW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_ENV_DW;
                    end
                end
                S_ENV_DW:
                begin
                    if (div_done)
                    begin
                        env_reg   <= esub_reg ? 16'(17'd32768 - {1'b0, div_q}) : div_q;
                        state_reg <= S_EMUL;
                    end
                end
                S_EMUL:
                begin
                    state_reg <= S_EMUL_WT;
                end
                S_EMUL_WT:
                begin
                    if (mul_done)
                    begin
                        vmag_reg  <= tprod;
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL:
                begin
                    neg_reg   <= neg_reg ^ trem_reg[17];
                    state_reg <= S_TMUL_WT;
                end
                S_TMUL_WT:
                begin
                    if (mul_done)
                    begin
                        vmag_reg  <= (tprod > 18'd32768) ? 18'd32768 : tprod;
                        state_reg <= S_FMUL;
                    end
                end
                S_FMUL:
                begin
                    state_reg <= S_FMUL_WT;
                end
                S_FMUL_WT:
                begin
                    if (mul_done)
                    begin
                        res_sample_reg <= neg_reg ? -$signed(fres) : $signed(fres);
                        res_last_reg   <= (i_x + XW'(1)) >= XW'(dur_reg);
                        res_play_reg   <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg     <= 1'b1;
                        sample_reg <= res_sample_reg;
                        last_reg   <= res_last_reg;
                        play_reg   <= res_play_reg;
                        if (res_play_reg)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        if (res_last_reg)
                        begin
                            active_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;
    assign playing   = play_reg;

endmodule

FILE: hdl/atv_sine.sv
// Quarter-wave sine ROM with registered read
module atv_sine (
    input  logic               clk,
    input  logic [31:0]        phase,
    output logic signed [15:0] value
);
    import atv_pkg::*;

    localparam int KW = SINE_BITS - 1;
    localparam qtab_t QTAB = build_qtab();
    localparam logic [KW-1:0] QUARTER = KW'(SINE_TABLE_SIZE / 4);

    logic [SINE_BITS-1:0] idx;
    logic [1:0]           quad;
    logic [KW-1:0]        r;
    logic [KW-1:0]        k;
    logic [14:0]          mag_reg;
    logic                 neg_reg;

    assign idx  = phase[31 -: SINE_BITS];
    assign quad = idx[SINE_BITS-1 -: 2];
    assign r    = KW'(idx[SINE_BITS-3:0]);
    assign k    = quad[0] ? (QUARTER - r) : r;

    always_ff @(posedge clk)
    begin
        mag_reg <= QTAB[k];
        neg_reg <= quad[1];
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

FILE: hdl/atv_mul.sv
// Bit-serial unsigned shift-add multiplier
module atv_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  atv_pkg::mul_req_t        req,
    output logic                     done,
    output logic [atv_pkg::MUL_P_W-1:0] prod
);
    import atv_pkg::*;

    localparam int CW = $clog2(MUL_B_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [MUL_A_W:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= req.a;
                hi_reg   <= '0;
                lo_reg   <= req.b;
            end
            else if (busy_reg)
            begin
                hi_reg  <= sum[MUL_A_W:1];
                lo_reg  <= {sum[0], lo_reg[MUL_B_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

FILE: hdl/atv_div.sv
// Bit-serial restoring divider, 16 quotient bits
module atv_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atv_pkg::div_req_t           req,
    output logic                        done,
    output logic [atv_pkg::DIV_Q_W-1:0] quot
);
    import atv_pkg::*;

    localparam int CW = $clog2(DIV_Q_W);
    localparam int RW = DIV_N_W - DIV_Q_W;

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [RW-1:0]      rem_reg;
    logic [DIV_Q_W-1:0] lo_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [RW:0]        trial;
    logic [RW:0]        diff;
    logic               ge;

    assign trial = {rem_reg, lo_reg[DIV_Q_W-1]};
    assign ge    = trial >= (RW+1)'(d_reg);
    assign diff  = trial - (RW+1)'(d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            lo_reg   <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= req.n[DIV_N_W-1:DIV_Q_W];
                lo_reg   <= req.n[DIV_Q_W-1:0];
                d_reg    <= req.d;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[RW-1:0] : trial[RW-1:0];
                lo_reg  <= {lo_reg[DIV_Q_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

FILE: hdl/atv_chk.sv
// Port-level checker for the tone voice, bound to the top level
`include "adsr_tone_voice_top_macros.svh"

module atv_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [atv_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [atv_pkg::CFG_W-1:0]     cfg_data,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          restart,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [15:0]            sample,
    input logic                          last,
    input logic                          playing
);

    `ATV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample) && $stable(last) && $stable(playing), "stalled sample beat changed")

    `ATV_ASSERT_SAME(a_idle_zero, out_valid && !playing, (sample == 16'sd0) && !last, "idle beat carries data")

    `ATV_ASSERT_SAME(a_range, out_valid, sample != -16'sd32768, "sample out of range")

    `ATV_ASSERT_NEXT(a_one_tick, in_valid && !in_stall, in_stall, "second tick taken while busy")

endmodule

bind adsr_tone_voice_top atv_chk u_atv_chk (.*);

FILE: sim/testbench.sv
// Self-checking bench for the synth voice: directed ticks, then random notes
module testbench;
    import atv_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 restart;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [15:0]   sample;
    logic                 last;
    logic                 playing;

    adsr_tone_voice_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .restart(restart), .out_valid(out_valid), .out_stall(out_stall),
        .sample(sample), .last(last), .playing(playing)
    );

    typedef struct {
        logic signed [15:0] smp;
        logic               lst;
        logic               ply;
    } voice_out_t;

    typedef struct {
        logic       rs;
        logic       known;
        voice_out_t res;
    } tick_row_t;

    // voice registers
    logic [2:0]  m_shape;
    logic [30:0] m_step;
    logic [15:0] m_amp;
    logic [59:0] m_env;
    logic [15:0] m_sus;
    logic [19:0] m_dur;
    logic [31:0] m_vib;
    logic [31:0] m_trem;
    // voice state
    logic [19:0] m_idx;
    logic [31:0] m_phase;
    logic [23:0] m_vphase;
    logic [23:0] m_tphase;
    logic [15:0] m_lfsr;
    logic        m_active;

    voice_out_t sample_queue[$];
    int         fails;
    int         idle_run;
    int         in_idle_pct;
    int         out_idle_pct;
    bit         hold_out;
    int         hold_len;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic longint qsine(longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 14;
        t  = (5223 * z2) >>> 14;
        t  = 42334 - t;
        t  = (t * z2) >>> 14;
        t  = 102944 - t;
        t  = (t * z) >>> 15;
        if (t > 32767)
        begin
            t = 32767;
        end
        return t;
    endfunction

    function automatic longint table_sine(logic [31:0] ph);
        longint ix;
        longint u;
        longint quad;
        longint r;
        longint m;
        ix   = longint'(ph) * SINE_TABLE_SIZE;
        ix   = ix >>> 32;
        u    = ((ix << 16) / SINE_TABLE_SIZE) & 65535;
        quad = u >>> 14;
        r    = u & 16383;
        m    = qsine((quad & 1) ? 16384 - r : r);
        return (quad >= 2) ? -m : m;
    endfunction

    function automatic longint shape_level(logic [31:0] p);
        logic lsb;
        case (m_shape)
            WAVE_SINE:     return table_sine(p);
            WAVE_SQUARE:   return p[31] ? -32768 : 32768;
            WAVE_SAW:      return longint'(p[31:16]) - 32768;
            WAVE_TRIANGLE: return p[31] ? 98304 - longint'(p[31:15])
                                        : longint'(p[31:15]) - 32768;
            WAVE_NOISE:
            begin
                lsb    = m_lfsr[0];
                m_lfsr = m_lfsr >> 1;
                if (lsb)
                begin
                    m_lfsr = m_lfsr ^ LFSR_MASK;
                end
                return longint'(m_lfsr) - 32768;
            end
            default:       return 0;
        endcase
    endfunction

    function automatic longint env_level(longint i, longint dur);
        longint a;
        longint d;
        longint rl;
        longint s;
        longint num;
        a  = m_env[19:0];
        d  = m_env[39:20];
        rl = m_env[59:40];
        s  = (m_sus == 0) ? 32768 : longint'(m_sus);
        if (s > 32768)
        begin
            s = 32768;
        end
        if (a > 0 && i < a)
        begin
            return i * 32768 / a;
        end
        if (d > 0 && i < a + d)
        begin
            return 32768 - (32768 - s) * (i - a) / d;
        end
        if (i < dur - rl)
        begin
            return s;
        end
        if (rl > 0)
        begin
            num = dur - i;
            if (num < 0)
            begin
                num = 0;
            end
            return s * num / rl;
        end
        return 0;
    endfunction

    function automatic voice_out_t voice_tick(logic rs);
        voice_out_t o;
        longint     i;
        longint     dur;
        longint     stp;
        longint     v;
        longint     amp;
        longint     trm;
        longint     half;
        if (rs)
        begin
            m_idx    = 0;
            m_phase  = 0;
            m_vphase = 0;
            m_tphase = 0;
            m_active = (m_dur != 0);
        end
        o = '{0, 0, 0};
        if (!m_active)
        begin
            return o;
        end
        i   = m_idx;
        dur = m_dur;
        stp = m_step;
        if (m_vib[15:0] != 0)
        begin
            stp += longint'(m_vib[31:16]) * table_sine({m_vphase, 8'h00}) / 32768;
        end
        m_vphase = m_vphase + m_vib[15:0];
        m_phase  = m_phase + stp[31:0];
        trm = 32768;
        if (m_trem[15:0] != 0)
        begin
            half = 32768 + table_sine({m_tphase, 8'h00});
            trm  = 32768 - (longint'(m_trem[31:16]) * half) / 65536;
        end
        m_tphase = m_tphase + m_trem[15:0];
        amp = (m_amp == 0) ? 26214 : longint'(m_amp);
        v = shape_level(m_phase) * amp / 32768;
        v = v * env_level(i, dur) / 32768;
        v = v * trm / 32768;
        if (v > 32768)
        begin
            v = 32768;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        v = v * 32767 / 32768;
        o.smp = v[15:0];
        o.lst = (i + 1) >= dur;
        o.ply = 1;
        m_idx = m_idx + 20'd1;
        if (o.lst)
        begin
            m_active = 0;
        end
        return o;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        case (idx)
            CFG_WAVE_SHAPE: m_shape = val[2:0];
            CFG_PHASE_STEP: m_step  = val[30:0];
            CFG_AMPLITUDE:  m_amp   = val[15:0];
            CFG_ENV_TIMES:  m_env   = val[59:0];
            CFG_SUSTAIN:    m_sus   = val[15:0];
            CFG_DURATION:   m_dur   = val[19:0];
            CFG_VIBRATO:    m_vib   = val[31:0];
            default:        m_trem  = val[31:0];
        endcase
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
    endtask

    // one tick beat; known rows carry a typed-in result
    task automatic send_tick(logic rs, bit known, voice_out_t res);
        voice_out_t p;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        restart  <= rs;
        p = voice_tick(rs);
        if (known && p != res)
        begin
            $error("table row disagrees with predictor");
            fails++;
        end
        sample_queue.push_back(p);
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic random_regs();
        int sz;
        write_reg(CFG_WAVE_SHAPE, CFG_W'($urandom_range(7)));
        write_reg(CFG_PHASE_STEP, CFG_W'({$urandom, $urandom} & 64'h7fffffff));
        write_reg(CFG_AMPLITUDE,
                  CFG_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(65535)));
        sz = $urandom_range(40);
        write_reg(CFG_ENV_TIMES, {20'($urandom_range(sz)),
                                  20'($urandom_range(sz)), 20'($urandom_range(sz))});
        write_reg(CFG_SUSTAIN,
                  CFG_W'(($urandom_range(4) == 0) ? 0 : $urandom_range(65535)));
        write_reg(CFG_DURATION,
                  CFG_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 50)));
        write_reg(CFG_VIBRATO, CFG_W'(($urandom_range(2) == 0) ? 0 : $urandom));
        write_reg(CFG_TREMOLO, CFG_W'(($urandom_range(2) == 0) ? 0 : $urandom));
    endtask

    always @(posedge clk)
    begin
        voice_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sample_queue.size() == 0)
            begin
                $error("sample beat with nothing expected");
                fails++;
            end
            else
            begin
                e = sample_queue.pop_front();
                if (sample !== e.smp)
                begin
                    $error("sample exp %0d got %0d", e.smp, sample);
                    fails++;
                end
                if (last !== e.lst)
                begin
                    $error("last exp %0d got %0d", e.lst, last);
                    fails++;
                end
                if (playing !== e.ply)
                begin
                    $error("playing exp %0d got %0d", e.ply, playing);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_out)
        begin
            out_stall <= 1;
            hold_len++;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            idle_run = 0;
        end
        else
        begin
            idle_run++;
            if (idle_run >= 20000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        tick_row_t rows[$];
        voice_out_t zero_out;
        int n;
        fails = 0; idle_run = 0; hold_out = 0; hold_len = 0;
        in_idle_pct = 13; out_idle_pct = 46;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; restart = 0; out_stall = 0;
        m_shape = 0; m_step = RST_PHASE_STEP; m_amp = RST_AMPLITUDE; m_env = 0;
        m_sus = RST_SUSTAIN; m_dur = RST_DURATION; m_vib = 0; m_trem = 0;
        m_idx = 0; m_phase = 0; m_vphase = 0; m_tphase = 0;
        m_lfsr = RST_LFSR; m_active = 0;
        zero_out = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // idle voice after reset, then short square notes at full scale
        rows = '{'{0, 1, zero_out}, '{0, 1, zero_out}};
        foreach (rows[k]) send_tick(rows[k].rs, rows[k].known, rows[k].res);
        wait_drained();
        write_reg(CFG_WAVE_SHAPE, CFG_W'(WAVE_SQUARE));
        write_reg(CFG_PHASE_STEP, CFG_W'(32'h7fffffff));
        write_reg(CFG_AMPLITUDE, CFG_W'(16'hffff));
        write_reg(CFG_DURATION, CFG_W'(20'd2));
        rows = '{'{1, 0, zero_out}, '{0, 0, zero_out}, '{0, 1, zero_out},
                 '{1, 0, zero_out}, '{1, 0, zero_out}, '{0, 0, zero_out}};
        foreach (rows[k]) send_tick(rows[k].rs, rows[k].known, rows[k].res);
        wait_drained();
        // zero duration keeps voice idle
        write_reg(CFG_DURATION, CFG_W'(20'd0));
        rows = '{'{1, 1, zero_out}, '{0, 1, zero_out}};
        foreach (rows[k]) send_tick(rows[k].rs, rows[k].known, rows[k].res);
        wait_drained();
        // every shape with envelope, zero gain/sustain, both LFOs, deep tremolo
        write_reg(CFG_DURATION, CFG_W'(20'd6));
        write_reg(CFG_AMPLITUDE, CFG_W'(16'd0));
        write_reg(CFG_SUSTAIN, CFG_W'(16'd0));
        write_reg(CFG_ENV_TIMES, {20'd2, 20'd1, 20'd2});
        write_reg(CFG_VIBRATO, CFG_W'(32'hffff_4000));
        write_reg(CFG_TREMOLO, CFG_W'(32'hffff_3000));
        for (int s = 0; s < 8; s++)
        begin
            wait_drained();
            write_reg(CFG_WAVE_SHAPE, CFG_W'(s));
            send_tick(1, 0, zero_out);
            send_tick(0, 0, zero_out);
        end
        wait_drained();
        // sustain above full scale, zero step with negative vibrato
        write_reg(CFG_SUSTAIN, CFG_W'(16'hffff));
        write_reg(CFG_ENV_TIMES, 60'hfffff_fffff_fffff);
        write_reg(CFG_DURATION, CFG_W'(20'hfffff));
        write_reg(CFG_PHASE_STEP, CFG_W'(31'd0));
        send_tick(1, 0, zero_out);
        send_tick(0, 0, zero_out);
        // shorten mid-note
        wait_drained();
        write_reg(CFG_DURATION, CFG_W'(20'd1));
        send_tick(0, 0, zero_out);
        send_tick(0, 0, zero_out);

        n = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            in_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 46 : 0;
            out_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 13 : 0;
            for (int k = 0; k < 200; k++)
            begin
                if (k % 40 == 0)
                begin
                    wait_drained();
                    random_regs();
                end
                if (ph == 1 && k == 100)
                begin
                    hold_out = 1;
                    hold_len = 0;
                    fork
                        begin
                            while (hold_len < 3000)
                            begin
                                @(posedge clk);
                            end
                            hold_out = 0;
                        end
                    join_none
                end
                send_tick($urandom_range(9) == 0, 0, zero_out);
                n++;
            end
        end

        while (sample_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (fails == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
